// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps

package sacl_pkg;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 30;
    localparam int IDX_W        = 12;
    localparam int SET_BITS_CAP = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

    localparam logic [3:0] RST_BLOCK_OFFSET_BITS = 4'd5;
    localparam logic [3:0] RST_SET_INDEX_BITS    = 4'd6;
    localparam logic [2:0] RST_WAYS_IN_USE       = 3'd4;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] tag;
    } t_req;

endpackage

// ===== rtl/set_assoc_cache_tag_lru_top.sv =====
`timescale 1ns / 1ps

// Tag and true-LRU replacement array of a set-associative cache. Each transaction carries a
// byte address and a kind (lookup or insert) and produces exactly one result, hit and
// way_used, presented on o_hit and o_way_used for a single cycle marked by o_done; the
// receiver cannot stall, so the result must be captured in that cycle. A transaction is
// accepted on a rising edge where start is high and busy is low. Each transaction passes
// through these steps in order: capture of the address, the set index reduction (a
// reciprocal multiply and a correction), the row read from the synchronous tag memory, and
// a step that compares the ways in use in parallel, chooses the victim, ages the ranks and
// writes the row back. o_done is high in the cycle after the write-back, and a new
// transaction can be accepted in that same cycle. After reset is released, busy stays high
// while a clearing pass zeroes every row of the memory. Configuration writes through
// i_cfg_we, i_cfg_idx and i_cfg_data take effect on the next edge and are sampled when a
// transaction is accepted; indexes outside the register list are ignored.
module set_assoc_cache_tag_lru_top
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_done,
    output logic                  o_hit,
    output logic [1:0]            o_way_used
);

    localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW = $clog2(MAX_WAYS + 1);

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_INDEX  = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [3:0]       r_cfg_ob;
    logic [3:0]       r_cfg_sb;
    logic [2:0]       r_cfg_ways;
    logic             r_go;
    logic             r_kind;
    logic [TAG_W-1:0] r_tag;
    logic [IDX_W-1:0] r_x;
    logic [WCW-1:0]   r_ways;
    logic             r_done;
    logic             r_hit;
    logic [1:0]       r_way_used;

    logic             accept;
    logic [3:0]       sb_eff;
    logic [ADDR_W-1:0] shifted;
    logic [IDX_W:0]   idx_mask;
    logic [IDX_W-1:0] n_x;
    logic [4:0]       tag_shift;
    logic [TAG_W-1:0] n_tag;
    logic [WCW-1:0]   n_ways;
    logic             idx_done;
    logic [SW-1:0]    idx_set;
    logic             arr_ready;
    logic             arr_hit;
    logic [WIW-1:0]   arr_way;
    t_req             req;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ob   <= RST_BLOCK_OFFSET_BITS;
            r_cfg_sb   <= RST_SET_INDEX_BITS;
            r_cfg_ways <= RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_OFFSET_BITS: r_cfg_ob   <= i_cfg_data;
                CFG_SET_INDEX_BITS:    r_cfg_sb   <= i_cfg_data;
                CFG_WAYS_IN_USE:       r_cfg_ways <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Address split: the set bits are capped, and the tag keeps its low bits only.
    // The ways count saturates into the range the array supports.
    always_comb begin
        sb_eff    = (int'(r_cfg_sb) > SET_BITS_CAP) ? 4'(SET_BITS_CAP) : r_cfg_sb;
        shifted   = i_address >> r_cfg_ob;
        idx_mask  = ((IDX_W + 1)'(1) << sb_eff) - (IDX_W + 1)'(1);
        n_x       = shifted[IDX_W-1:0] & idx_mask[IDX_W-1:0];
        tag_shift = 5'(r_cfg_ob) + 5'(sb_eff);
        n_tag     = TAG_W'(i_address >> tag_shift);
        if (r_cfg_ways == 3'd0) begin
            n_ways = WCW'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            n_ways = WCW'(MAX_WAYS);
        end else begin
            n_ways = WCW'(r_cfg_ways);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_tag  <= n_tag;
            r_x    <= n_x;
            r_ways <= n_ways;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (arr_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (idx_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_go    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= accept;
            r_done  <= (r_state == ST_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_hit      <= arr_hit;
            r_way_used <= 2'(arr_way);
        end
    end

    sacl_set_index #(
        .MAX_SETS (MAX_SETS)
    ) u_set_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_x     (r_x),
        .o_done  (idx_done),
        .o_set   (idx_set)
    );

    assign req.kind = r_kind;
    assign req.tag  = r_tag;

    // The row is read when the set index is ready and written back in the update cycle on a hit or an insert.
    sacl_tag_array #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_tag_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en ((r_state == ST_INDEX) && idx_done),
        .i_set   (idx_set),
        .i_upd   (r_state == ST_UPDATE),
        .i_req   (req),
        .i_ways  (r_ways),
        .o_ready (arr_ready),
        .o_hit   (arr_hit),
        .o_way   (arr_way)
    );

    assign o_done     = r_done;
    assign o_hit      = r_hit;
    assign o_way_used = r_way_used;

    a_done_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_UPDATE))
        else $error("result strobe without a preceding update cycle");

    a_accept_enters_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_INDEX))
        else $error("accepted transaction did not start set index computation");

    a_lookup_miss_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit && (r_kind == KIND_LOOKUP)) |-> (o_way_used == 2'd0))
        else $error("lookup miss reported a nonzero way");

endmodule

// ===== rtl/sacl_set_index.sv =====
`timescale 1ns / 1ps

module sacl_set_index
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [IDX_W-1:0]     i_x,
    output logic                 o_done,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] o_set
);

    localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam bit POW2  = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    localparam int SH    = 24;
    localparam int PW    = IDX_W + SH;
    localparam int RECIP = (1 << SH) / MAX_SETS;
    localparam int MW    = 25;

    logic               r_v1;
    logic               r_v2;
    logic [IDX_W-1:0]   r_x;
    logic [IDX_W-1:0]   r_q;
    logic [SW-1:0]      r_set;
    logic [IDX_W-1:0]   n_q;
    logic [SW-1:0]      n_set;
    logic [PW-1:0]      prod;
    logic [MW-1:0]      qm;
    logic [MW-1:0]      rem;
    logic [MW-1:0]      rem_c;

    // The quotient estimate is at most one short, so one correction step suffices.
    always_comb begin
        prod  = PW'(i_x) * PW'(RECIP);
        n_q   = prod[PW-1:SH];
        qm    = MW'(r_q) * MW'(MAX_SETS);
        rem   = MW'(r_x) - qm;
        rem_c = (rem >= MW'(MAX_SETS)) ? (rem - MW'(MAX_SETS)) : rem;
        if (POW2) begin
            n_set = SW'(r_x & IDX_W'(MAX_SETS - 1));
        end else begin
            n_set = rem_c[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_q <= n_q;
        end
        if (r_v1) begin
            r_set <= n_set;
        end
    end

    assign o_done = r_v2;
    assign o_set  = r_set;

endmodule

// ===== rtl/sacl_way_logic.sv =====
`timescale 1ns / 1ps

module sacl_way_logic
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = 4
) (
    input  t_req                                                   i_req,
    input  logic [$clog2(MAX_WAYS + 1)-1:0]                        i_ways,
    input  logic [MAX_WAYS*(1+TAG_W+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] i_row,
    output logic                                                   o_hit,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]     o_way,
    output logic                                                   o_write,
    output logic [MAX_WAYS*(1+TAG_W+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] o_row
);

    localparam int RW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WIW = RW;
    localparam int WCW = $clog2(MAX_WAYS + 1);
    localparam int WB  = 1 + TAG_W + RW;

    logic [MAX_WAYS-1:0]  valid;
    logic [TAG_W-1:0]     tag   [MAX_WAYS];
    logic [RW-1:0]        rank  [MAX_WAYS];
    logic [RW-1:0]        n_rank[MAX_WAYS];
    logic [MAX_WAYS-1:0]  in_use;
    logic [MAX_WAYS-1:0]  match;
    logic [MAX_WAYS-1:0]  empty;
    logic [MAX_WAYS-1:0]  lru_cand;
    logic                 any_empty;
    logic [WIW-1:0]       hit_way;
    logic [WIW-1:0]       empty_way;
    logic [WIW-1:0]       lru_way;
    logic [WIW-1:0]       touch;
    logic [RW-1:0]        touch_rank;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            valid[i]  = i_row[i*WB];
            tag[i]    = i_row[i*WB+1 +: TAG_W];
            rank[i]   = i_row[i*WB+1+TAG_W +: RW];
            in_use[i] = (WCW'(i) < i_ways);
            match[i]  = in_use[i] && valid[i] && (tag[i] == i_req.tag);
            empty[i]  = in_use[i] && !valid[i];
        end

        // A way is the victim candidate if it ranks strictly below every lower way in use
        // and no higher than every upper way in use, so ties go to the lowest way.
        for (int i = 0; i < MAX_WAYS; i++) begin
            lru_cand[i] = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (in_use[j] && (j < i) && !(rank[i] < rank[j])) begin
                    lru_cand[i] = 1'b0;
                end
                if (in_use[j] && (j > i) && (rank[j] < rank[i])) begin
                    lru_cand[i] = 1'b0;
                end
            end
        end

        hit_way   = '0;
        empty_way = '0;
        lru_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WIW'(i);
            end
            if (empty[i]) begin
                empty_way = WIW'(i);
            end
            if (lru_cand[i]) begin
                lru_way = WIW'(i);
            end
        end
        any_empty = |empty;
        o_hit     = |match;

        if (o_hit) begin
            touch = hit_way;
        end else if (any_empty) begin
            touch = empty_way;
        end else begin
            touch = lru_way;
        end
        touch_rank = rank[touch];

        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WIW'(i) == touch) begin
                n_rank[i] = RW'(i_ways - WCW'(1));
            end else if (in_use[i] && (rank[i] > touch_rank)) begin
                n_rank[i] = rank[i] - RW'(1);
            end else begin
                n_rank[i] = rank[i];
            end
        end

        o_row = i_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_row[i*WB+1+TAG_W +: RW] = n_rank[i];
            if (WIW'(i) == touch) begin
                o_row[i*WB]            = 1'b1;
                o_row[i*WB+1 +: TAG_W] = i_req.tag;
            end
        end

        o_write = o_hit || (i_req.kind == KIND_INSERT);
        o_way   = (o_hit || (i_req.kind == KIND_INSERT)) ? touch : '0;
    end

endmodule

// ===== rtl/sacl_tag_array.sv =====
`timescale 1ns / 1ps

module sacl_tag_array
    import sacl_pkg::*;
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 4
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_rd_en,
    input  logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] i_set,
    input  logic                                               i_upd,
    input  t_req                                               i_req,
    input  logic [$clog2(MAX_WAYS + 1)-1:0]                    i_ways,
    output logic                                               o_ready,
    output logic                                               o_hit,
    output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_way
);

    localparam int SW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WB    = 1 + TAG_W + RW;
    localparam int ROW_W = MAX_WAYS * WB;
    localparam int CW    = $clog2(MAX_SETS + 1);

    logic [ROW_W-1:0] mem [MAX_SETS];
    logic [ROW_W-1:0] r_rd_data;
    logic [CW-1:0]    r_clr_cnt;
    logic [ROW_W-1:0] upd_row;
    logic             upd_write;
    logic             we;
    logic [SW-1:0]    wa;
    logic [ROW_W-1:0] wd;

    sacl_way_logic #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_logic (
        .i_req   (i_req),
        .i_ways  (i_ways),
        .i_row   (r_rd_data),
        .o_hit   (o_hit),
        .o_way   (o_way),
        .o_write (upd_write),
        .o_row   (upd_row)
    );

    // After reset every row is written with zeros, one row per cycle.
    assign o_ready = (r_clr_cnt == CW'(MAX_SETS));

    always_comb begin
        if (!o_ready) begin
            we = 1'b1;
            wa = r_clr_cnt[SW-1:0];
            wd = '0;
        end else begin
            we = i_upd && upd_write;
            wa = i_set;
            wd = upd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (!o_ready) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_set];
        end
    end

endmodule

// ===== sim/set_assoc_cache_tag_lru_top_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the cache tag and LRU array. Every accepted access is
// mirrored into a scoreboard that keeps its own copy of the valid bits, tags and
// recency ranks. It queues the hit and way it expects, and the monitor compares
// each o_done strobe against the oldest queued entry.
module set_assoc_cache_tag_lru_top_test;
    import sacl_pkg::*;

    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 4;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 10;
    // Index 3 is not a register, so writes to it must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Scoreboard: predicts the result of each access and checks what comes back.
    class tag_lru_scoreboard;
        typedef struct {
            bit       hit;
            bit [1:0] way_used;
        } t_access_result;

        bit [3:0]       blk_bits;
        bit [3:0]       set_bits;
        bit [2:0]       ways;
        bit             valid_bits [MAX_SETS][MAX_WAYS];
        bit [TAG_W-1:0] tags       [MAX_SETS][MAX_WAYS];
        bit [1:0]       ranks      [MAX_SETS][MAX_WAYS];
        t_access_result expected_results[$];
        int             errors;

        function new();
            blk_bits = RST_BLOCK_OFFSET_BITS;
            set_bits = RST_SET_INDEX_BITS;
            ways     = RST_WAYS_IN_USE;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLOCK_OFFSET_BITS: blk_bits = data;
                CFG_SET_INDEX_BITS:    set_bits = data;
                CFG_WAYS_IN_USE:       ways = data[2:0];
                default: ;
            endcase
        endfunction

        // Make a way most recent; only the ways that were more recent age by one.
        function void promote(int set_idx, int way, int active);
            bit [1:0] old_rank;
            old_rank = ranks[set_idx][way];
            for (int i = 0; i < active; i++) begin
                if (i != way && ranks[set_idx][i] > old_rank)
                    ranks[set_idx][i] = ranks[set_idx][i] - 2'd1;
            end
            ranks[set_idx][way] = 2'(active - 1);
        endfunction

        function void note_access(logic kind, logic [ADDR_W-1:0] addr);
            int             active;
            int             sbits;
            int             set_idx;
            int             way;
            bit [TAG_W-1:0] tag;
            bit             hit;
            bit             found;
            t_access_result res;
            active = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
            sbits = (set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(set_bits);
            set_idx = int'((addr >> blk_bits) & ((32'd1 << sbits) - 32'd1)) % MAX_SETS;
            tag = TAG_W'(addr >> (int'(blk_bits) + sbits));
            hit = 1'b0;
            way = 0;
            // The lowest-numbered matching way wins when a tag sits in several ways.
            for (int i = 0; i < active && !hit; i++) begin
                if (valid_bits[set_idx][i] && tags[set_idx][i] == tag) begin
                    hit = 1'b1;
                    way = i;
                end
            end
            if (hit) begin
                promote(set_idx, way, active);
            end else if (kind == KIND_INSERT) begin
                found = 1'b0;
                for (int i = 0; i < active && !found; i++) begin
                    if (!valid_bits[set_idx][i]) begin
                        way = i;
                        found = 1'b1;
                    end
                end
                // No free way: evict the least recent one, lowest way on a tie.
                if (!found) begin
                    way = 0;
                    for (int i = 1; i < active; i++) begin
                        if (ranks[set_idx][i] < ranks[set_idx][way])
                            way = i;
                    end
                end
                valid_bits[set_idx][way] = 1'b1;
                tags[set_idx][way] = tag;
                promote(set_idx, way, active);
            end
            res.hit = hit;
            res.way_used = 2'(way);
            expected_results.push_back(res);
        endfunction

        function void check_result(logic hit, logic [1:0] way_used);
            t_access_result exp_res;
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding: hit=%0d way_used=%0d",
                       hit, way_used);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (hit !== exp_res.hit) begin
                $error("hit: expected %0d, actual %0d", exp_res.hit, hit);
                errors++;
            end
            if (way_used !== exp_res.way_used) begin
                $error("way_used: expected %0d, actual %0d", exp_res.way_used, way_used);
                errors++;
            end
        endfunction

        function void check_drained();
            foreach (expected_results[i]) begin
                $error("missing result: expected hit=%0d way_used=%0d",
                       expected_results[i].hit, expected_results[i].way_used);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_kind = KIND_LOOKUP;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_done;
    logic                  o_hit;
    logic [1:0]            o_way_used;

    tag_lru_scoreboard tag_sb = new();

    int                idle_pct = 27;
    int                items_sent = 0;
    int                stall_cycles = 0;
    logic [ADDR_W-1:0] tag_base;
    logic [ADDR_W-1:0] set_base;
    logic [ADDR_W-1:0] recent_addrs[$];

    set_assoc_cache_tag_lru_top #(
        .MAX_SETS(MAX_SETS),
        .MAX_WAYS(MAX_WAYS)
    ) dut (.*);

    always #5 i_clk = ~i_clk;

    // The receiver cannot stall, so every strobe is checked in the cycle it appears.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tag_sb.check_result(o_hit, o_way_used);
    end

    // Watchdog: any transaction, result or register write counts as progress. The
    // limit covers the clearing pass after reset and the longest sender gap with room
    // to spare.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one access and hold it until the block takes it. Start stays high after
    // a transaction unless the sender decides to idle, so back-to-back transactions
    // never lower and raise it in the same step.
    task automatic send_access(logic kind, logic [ADDR_W-1:0] addr);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        tag_sb.note_access(kind, addr);
        items_sent++;
        // Light sender gaps first, heavy gaps next, then full rate.
        idle_pct = (items_sent < 367) ? 27 : ((items_sent < 733) ? 52 : 0);
    endtask

    // Stop offering work and wait until every outstanding result has come back.
    // The count is polled on the falling edge so it never races the monitor.
    task automatic drain_results();
        start <= 1'b0;
        while (tag_sb.expected_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Register writes go out on consecutive edges with the write enable held high,
    // followed by a write to the unused index that must change nothing.
    task automatic set_config(logic [3:0] blk, logic [3:0] sets, logic [2:0] nways);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BLOCK_OFFSET_BITS;
        i_cfg_data <= blk;
        @(posedge i_clk);
        tag_sb.write_reg(CFG_BLOCK_OFFSET_BITS, blk);
        i_cfg_idx  <= CFG_SET_INDEX_BITS;
        i_cfg_data <= sets;
        @(posedge i_clk);
        tag_sb.write_reg(CFG_SET_INDEX_BITS, sets);
        i_cfg_idx  <= CFG_WAYS_IN_USE;
        i_cfg_data <= {1'b0, nways};
        @(posedge i_clk);
        tag_sb.write_reg(CFG_WAYS_IN_USE, {1'b0, nways});
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Most addresses either revisit a recent block or pile onto a handful of sets
    // with a handful of tags, so that hits, refreshes and evictions are common. The
    // rest are fully random. Adding 256 to the set exercises the wrap of wide set
    // indexes onto the same row.
    function automatic logic [ADDR_W-1:0] pick_address();
        int                sel;
        int                ob;
        int                sbits;
        logic [ADDR_W-1:0] offs_mask;
        logic [ADDR_W-1:0] set_part;
        logic [ADDR_W-1:0] addr;
        ob = tag_sb.blk_bits;
        sbits = (tag_sb.set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(tag_sb.set_bits);
        offs_mask = (32'd1 << ob) - 32'd1;
        sel = $urandom_range(0, 99);
        if (sel < 40 && recent_addrs.size() != 0) begin
            addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
            addr = (addr & ~offs_mask) | ($urandom & offs_mask);
        end else if (sel < 85) begin
            set_part = (set_base + $urandom_range(0, 2) + ($urandom_range(0, 1) << 8))
                       & ((32'd1 << sbits) - 32'd1);
            addr = ((tag_base + $urandom_range(0, 6)) << (ob + sbits))
                   | (set_part << ob) | ($urandom & offs_mask);
        end else begin
            addr = $urandom;
        end
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 24)
            void'(recent_addrs.pop_front());
        return addr;
    endfunction

    task automatic run_phase(logic [3:0] blk, logic [3:0] sets, logic [2:0] nways);
        set_config(blk, sets, nways);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_access($urandom_range(0, 1) ? KIND_INSERT : KIND_LOOKUP, pick_address());
            // Now and then the sender holds off until the pipeline is empty.
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        tag_base = $urandom;
        set_base = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses under the reset configuration: 32-byte blocks, 64 sets,
        // four ways. Set 0 tag t lives at address t << 11.
        send_access(KIND_LOOKUP, 32'h0000_0000);    // cold miss reports way 0
        send_access(KIND_INSERT, 32'h0000_0000);    // fills the first free way
        send_access(KIND_LOOKUP, 32'h0000_001F);    // same block, other offset
        send_access(KIND_INSERT, 32'h0000_0000);    // insert of a resident tag refreshes
        send_access(KIND_LOOKUP, 32'hFFFF_FFFF);
        send_access(KIND_INSERT, 32'hFFFF_FFFF);
        send_access(KIND_LOOKUP, 32'hFFFF_FFE0);
        send_access(KIND_INSERT, 32'h0000_0800);    // set 0 fills up
        send_access(KIND_INSERT, 32'h0000_1000);
        send_access(KIND_INSERT, 32'h0000_1800);
        send_access(KIND_LOOKUP, 32'h0000_0000);    // oldest way becomes newest
        send_access(KIND_INSERT, 32'h0000_2000);    // evicts the least recent way
        send_access(KIND_LOOKUP, 32'h0000_0800);    // the evicted tag now misses
        send_access(KIND_LOOKUP, 32'h0000_1000);
        send_access(KIND_INSERT, 32'h0000_2800);
        send_access(KIND_INSERT, 32'hFFFF_F800);    // all-ones tag in set 0
        send_access(KIND_LOOKUP, 32'h0000_0000);
        send_access(KIND_LOOKUP, 32'h8000_0000);
        send_access(KIND_INSERT, 32'h8000_0000);
        send_access(KIND_INSERT, 32'h5555_5555);
        send_access(KIND_LOOKUP, 32'hAAAA_AAAA);
        send_access(KIND_INSERT, 32'hAAAA_AAAA);
        send_access(KIND_LOOKUP, 32'h5555_5555);
        drain_results();

        // Same geometry while the way count moves from four to one and back, so that
        // one tag can end up in several ways of a set. Then the extremes and a mix.
        run_phase(4'd5, 4'd6, 3'd4);
        run_phase(4'd5, 4'd6, 3'd1);
        run_phase(4'd5, 4'd6, 3'd4);
        run_phase(4'd0, 4'd0, 3'd0);
        run_phase(4'd15, 4'd15, 3'd7);
        run_phase(4'd2, 4'd12, 3'd3);
        run_phase(4'd8, 4'd8, 3'd2);
        run_phase(4'd3, 4'd13, 3'd5);
        run_phase(4'd4, 4'd2, 3'd4);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tag_sb.check_drained();
        if (tag_sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
